FILE: rtl/cell_list_neighbor_search_macros.svh
// assertion macros used by the port checker
`ifndef CELL_LIST_NEIGHBOR_SEARCH_MACROS_SVH
`define CELL_LIST_NEIGHBOR_SEARCH_MACROS_SVH

// condition that holds at every edge outside reset
`define CLNS_ASSERT_NOW(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("check failed");

// same-cycle implication
`define CLNS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");

// next-cycle implication
`define CLNS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");

`endif

FILE: rtl/clns_pkg.sv
// shared types, constants and helpers of the cell list neighbor search
`timescale 1ns / 1ps
package clns_pkg;
    localparam int MAX_PARTICLES   = 1024;
    localparam int PIDX_W          = 10;
    localparam int CELL_W          = 12;
    localparam int CELL_COUNT      = 4096;
    localparam int MAX_NEIGHBORS   = 64;
    localparam int CNT_W           = 7;

    typedef logic [1:0]        t_kind;
    typedef logic [PIDX_W-1:0] t_pidx;
    typedef logic [15:0]       t_pos;
    typedef logic [2:0]        t_cfg_idx;
    typedef logic [31:0]       t_cfg_data;

    localparam t_kind KIND_CLEAR  = 2'd0;
    localparam t_kind KIND_INSERT = 2'd1;
    localparam t_kind KIND_QUERY  = 2'd2;
    localparam t_kind KIND_UNUSED = 2'd3;

    localparam t_cfg_idx CFG_CELLS_X = 3'd0;
    localparam t_cfg_idx CFG_CELLS_Y = 3'd1;
    localparam t_cfg_idx CFG_CELLS_Z = 3'd2;
    localparam t_cfg_idx CFG_BOX_X   = 3'd3;
    localparam t_cfg_idx CFG_BOX_Y   = 3'd4;
    localparam t_cfg_idx CFG_BOX_Z   = 3'd5;
    localparam t_cfg_idx CFG_CUTOFF  = 3'd6;

    // neighbor offset codes along one axis, in walk order
    localparam logic [1:0] WALK_ZERO  = 2'd0;
    localparam logic [1:0] WALK_PLUS  = 2'd1;
    localparam logic [1:0] WALK_MINUS = 2'd2;

    function automatic logic [3:0] clns_wrap(input logic [3:0] idx, input logic [1:0] code,
                                             input logic [4:0] m);
        logic [4:0] up;
        logic [4:0] mm1;
        up  = {1'b0, idx} + 5'd1;
        mm1 = m - 5'd1;
        case (code)
            WALK_PLUS:  clns_wrap = (up >= m) ? 4'd0 : up[3:0];
            WALK_MINUS: clns_wrap = (idx == 4'd0) ? mm1[3:0] : idx - 4'd1;
            default:    clns_wrap = idx;
        endcase
    endfunction
endpackage

FILE: rtl/cell_list_neighbor_search.sv
// cell list neighbor search: cell grid, particle chains and query walk
// clear: one cell head per cycle; not ready meanwhile
// insert: three 20-step restoring divisions for the cell coordinates, unless already on a list
// query: three divisions for its own cell, then a head read per neighbor cell visited and
//   three 20-step divisions in the shared divider per particle tested, plus output stalls
// reset: synchronous, then a clearing pass of the cell heads before ready
`timescale 1ns / 1ps
module cell_list_neighbor_search (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  clns_pkg::t_kind       i_kind,
    input  clns_pkg::t_pidx       i_particle,
    input  clns_pkg::t_pos        i_pos_x,
    input  clns_pkg::t_pos        i_pos_y,
    input  clns_pkg::t_pos        i_pos_z,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output clns_pkg::t_pidx       o_neighbor,
    output logic                  o_found,
    output logic                  o_last,
    output logic                  o_truncated,
    input  logic                  i_cfg_we,
    input  clns_pkg::t_cfg_idx    i_cfg_index,
    input  clns_pkg::t_cfg_data   i_cfg_data
);
    import clns_pkg::*;

    typedef enum logic [19:0] {
        S_SWEEP    = 20'h00001,
        S_IDLE     = 20'h00002,
        S_INS_WAIT = 20'h00004,
        S_INS_CHK  = 20'h00008,
        S_Q_RD     = 20'h00010,
        S_Q_LD     = 20'h00020,
        S_AX       = 20'h00040,
        S_DIV      = 20'h00080,
        S_AX_DONE  = 20'h00100,
        S_CELL_A   = 20'h00200,
        S_CELL_B   = 20'h00400,
        S_HDW      = 20'h00800,
        S_HD       = 20'h01000,
        S_PRD      = 20'h02000,
        S_PD       = 20'h04000,
        S_DIST     = 20'h08000,
        S_SQ       = 20'h10000,
        S_CMP      = 20'h20000,
        S_NEXT     = 20'h40000,
        S_FIN      = 20'h80000
    } t_state;

    t_state r_state;

    // configuration
    logic [4:0]  r_cells_x, r_cells_y, r_cells_z;
    logic [16:0] r_box_x, r_box_y, r_box_z;
    logic [31:0] r_cutoff;

    // item and walk state
    t_pidx       r_particle;
    logic        r_is_query;
    logic        r_is_dist;
    t_pos        r_x0, r_y0, r_z0;
    logic [47:0] r_cand;
    logic [10:0] r_lnk;
    t_pidx       r_q;
    logic [1:0]  r_ax;
    logic [3:0]  r_ci, r_cj, r_ck, r_wi;
    logic [1:0]  r_wx, r_wy, r_wz;
    logic [8:0]  r_tmp;
    logic [CELL_W-1:0] r_cell;
    logic [CELL_W-1:0] r_sweep;
    logic [CNT_W-1:0]  r_count;
    t_pidx       r_pend;

    // shared divider
    logic [16:0] r_div;
    logic [19:0] r_dvd;
    logic [19:0] r_quo;
    logic [16:0] r_rem;
    logic [4:0]  r_dcnt;

    logic [15:0] r_rr;
    logic [31:0] r_acc;

    // output register
    logic        r_out_valid;
    t_pidx       r_out_nb;
    logic        r_out_found, r_out_last, r_out_trunc;

    // memories
    logic [10:0] r_head_mem   [CELL_COUNT];
    logic        r_linked_mem [MAX_PARTICLES];
    logic [10:0] r_link_mem   [MAX_PARTICLES];
    logic [47:0] r_pos_mem    [MAX_PARTICLES];
    logic [10:0] r_head_rd;
    logic        r_linked_rd;
    logic [10:0] r_link_rd;
    logic [47:0] r_pos_rd;

    // clamped configuration
    logic [4:0]  w_mx, w_my, w_mz;
    logic [16:0] w_lx, w_ly, w_lz;
    always_comb begin
        w_mx = (r_cells_x < 5'd3) ? 5'd3 : ((r_cells_x > 5'd16) ? 5'd16 : r_cells_x);
        w_my = (r_cells_y < 5'd3) ? 5'd3 : ((r_cells_y > 5'd16) ? 5'd16 : r_cells_y);
        w_mz = (r_cells_z < 5'd3) ? 5'd3 : ((r_cells_z > 5'd16) ? 5'd16 : r_cells_z);
        w_lx = (r_box_x == 17'd0) ? 17'd1 : ((r_box_x > 17'h10000) ? 17'h10000 : r_box_x);
        w_ly = (r_box_y == 17'd0) ? 17'd1 : ((r_box_y > 17'h10000) ? 17'h10000 : r_box_y);
        w_lz = (r_box_z == 17'd0) ? 17'd1 : ((r_box_z > 17'h10000) ? 17'h10000 : r_box_z);
    end

    // per-axis selection
    logic [4:0]  w_m;
    logic [16:0] w_l;
    t_pos        w_p0, w_pc;
    always_comb begin
        case (r_ax)
            2'd1: begin
                w_m = w_my; w_l = w_ly; w_p0 = r_y0; w_pc = r_cand[31:16];
            end
            2'd2: begin
                w_m = w_mz; w_l = w_lz; w_p0 = r_z0; w_pc = r_cand[15:0];
            end
            default: begin
                w_m = w_mx; w_l = w_lx; w_p0 = r_x0; w_pc = r_cand[47:32];
            end
        endcase
    end

    logic [19:0] w_prod;
    t_pos        w_ad;
    logic [17:0] w_trial, w_sub;
    logic        w_ge;
    logic [4:0]  w_mm1;
    logic [3:0]  w_cq;
    logic [16:0] w_lr;
    logic [15:0] w_rr;
    logic [31:0] w_sq;
    logic        w_match;
    logic [3:0]  w_wi, w_wj, w_wk;
    logic [8:0]  w_tmp;
    logic [CELL_W-1:0] w_cell;
    logic        w_out_free;
    logic        w_out_set;

    assign w_prod  = {4'd0, w_p0} * {15'd0, w_m};
    assign w_ad    = (w_pc >= w_p0) ? w_pc - w_p0 : w_p0 - w_pc;
    assign w_trial = {r_rem, r_dvd[19]};
    assign w_ge    = (w_trial >= {1'b0, r_div});
    assign w_sub   = w_trial - {1'b0, r_div};
    assign w_mm1   = w_m - 5'd1;
    assign w_cq    = (r_quo > {15'd0, w_mm1}) ? w_mm1[3:0] : r_quo[3:0];
    // distance to the nearest box image, ties give the same value either way
    assign w_lr    = w_l - r_rem;
    assign w_rr    = (r_rem < w_lr) ? r_rem[15:0] : w_lr[15:0];
    assign w_sq    = {16'd0, r_rr} * {16'd0, r_rr};
    assign w_match = (r_acc != 32'd0) && (r_acc <= r_cutoff);
    assign w_wi    = clns_wrap(r_ci, r_wx, w_mx);
    assign w_wj    = clns_wrap(r_cj, r_wy, w_my);
    assign w_wk    = clns_wrap(r_ck, r_wz, w_mz);
    assign w_tmp   = ({4'd0, w_my} * {5'd0, w_wk}) + {5'd0, w_wj};
    assign w_cell  = ({7'd0, w_mx} * {3'd0, r_tmp}) + {8'd0, r_wi};
    assign w_out_free = !r_out_valid || i_out_ready;
    // a result is loaded when a held match is passed on or the walk closes
    assign w_out_set  = w_out_free
                      && (((r_state == S_CMP) && w_match && (r_count != '0))
                          || (r_state == S_FIN));

    // memory write controls
    logic        w_ins_wr;
    logic        w_sweeping;
    assign w_sweeping = (r_state == S_SWEEP);
    assign w_ins_wr   = (r_state == S_HD) && !r_is_query;

    always_ff @(posedge i_clk) begin
        if (w_sweeping) begin
            r_head_mem[r_sweep] <= 11'd0;
        end else if (w_ins_wr) begin
            r_head_mem[r_cell] <= {1'b1, r_particle};
        end
        r_head_rd <= r_head_mem[r_cell];
    end

    always_ff @(posedge i_clk) begin
        if (w_sweeping && (r_sweep[CELL_W-1:PIDX_W] == '0)) begin
            r_linked_mem[r_sweep[PIDX_W-1:0]] <= 1'b0;
        end else if (w_ins_wr) begin
            r_linked_mem[r_particle] <= 1'b1;
        end
        r_linked_rd <= r_linked_mem[r_particle];
    end

    always_ff @(posedge i_clk) begin
        if (w_ins_wr) begin
            r_link_mem[r_particle] <= r_head_rd;
            r_pos_mem[r_particle]  <= {r_x0, r_y0, r_z0};
        end
        r_link_rd <= r_link_mem[r_q];
        r_pos_rd  <= r_pos_mem[(r_state == S_Q_RD) ? r_particle : r_q];
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cells_x <= 5'd4;
            r_cells_y <= 5'd4;
            r_cells_z <= 5'd4;
            r_box_x   <= 17'h10000;
            r_box_y   <= 17'h10000;
            r_box_z   <= 17'h10000;
            r_cutoff  <= 32'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_CELLS_X: r_cells_x <= i_cfg_data[4:0];
                CFG_CELLS_Y: r_cells_y <= i_cfg_data[4:0];
                CFG_CELLS_Z: r_cells_z <= i_cfg_data[4:0];
                CFG_BOX_X:   r_box_x   <= i_cfg_data[16:0];
                CFG_BOX_Y:   r_box_y   <= i_cfg_data[16:0];
                CFG_BOX_Z:   r_box_z   <= i_cfg_data[16:0];
                CFG_CUTOFF:  r_cutoff  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_SWEEP;
            r_sweep     <= '0;
            r_out_valid <= 1'b0;
            r_count     <= '0;
            r_ax        <= 2'd0;
            r_is_query  <= 1'b0;
            r_is_dist   <= 1'b0;
            r_wx        <= WALK_ZERO;
            r_wy        <= WALK_ZERO;
            r_wz        <= WALK_ZERO;
            r_dcnt      <= 5'd0;
        end else begin
            if (w_out_set) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_SWEEP: begin
                    r_sweep <= r_sweep + 1'b1;
                    if (r_sweep == '1) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_particle <= i_particle;
                        r_x0       <= i_pos_x;
                        r_y0       <= i_pos_y;
                        r_z0       <= i_pos_z;
                        r_is_query <= (i_kind == KIND_QUERY);
                        r_is_dist  <= 1'b0;
                        r_ax       <= 2'd0;
                        r_count    <= '0;
                        r_wx       <= WALK_ZERO;
                        r_wy       <= WALK_ZERO;
                        r_wz       <= WALK_ZERO;
                        case (i_kind)
                            KIND_CLEAR: begin
                                r_sweep <= '0;
                                r_state <= S_SWEEP;
                            end
                            KIND_INSERT: r_state <= S_INS_WAIT;
                            KIND_QUERY:  r_state <= S_Q_RD;
                            default:     r_state <= S_IDLE;
                        endcase
                    end
                end
                S_INS_WAIT: r_state <= S_INS_CHK;
                S_INS_CHK: begin
                    // a particle already on a list is left alone
                    r_state <= r_linked_rd ? S_IDLE : S_AX;
                end
                S_Q_RD: r_state <= S_Q_LD;
                S_Q_LD: begin
                    r_x0    <= r_pos_rd[47:32];
                    r_y0    <= r_pos_rd[31:16];
                    r_z0    <= r_pos_rd[15:0];
                    r_state <= S_AX;
                end
                S_AX: begin
                    r_div   <= w_l;
                    r_dvd   <= r_is_dist ? {4'd0, w_ad} : w_prod;
                    r_rem   <= 17'd0;
                    r_quo   <= 20'd0;
                    r_dcnt  <= 5'd19;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_rem <= w_ge ? w_sub[16:0] : w_trial[16:0];
                    r_quo <= {r_quo[18:0], w_ge};
                    r_dvd <= {r_dvd[18:0], 1'b0};
                    r_dcnt <= r_dcnt - 5'd1;
                    if (r_dcnt == 5'd0) begin
                        r_state <= r_is_dist ? S_DIST : S_AX_DONE;
                    end
                end
                S_AX_DONE: begin
                    case (r_ax)
                        2'd1:    r_cj <= w_cq;
                        2'd2:    r_ck <= w_cq;
                        default: r_ci <= w_cq;
                    endcase
                    if (r_ax == 2'd2) begin
                        r_state <= S_CELL_A;
                    end else begin
                        r_ax    <= r_ax + 2'd1;
                        r_state <= S_AX;
                    end
                end
                S_CELL_A: begin
                    r_tmp   <= w_tmp;
                    r_wi    <= w_wi;
                    r_state <= S_CELL_B;
                end
                S_CELL_B: begin
                    r_cell  <= w_cell;
                    r_state <= S_HDW;
                end
                S_HDW: r_state <= S_HD;
                S_HD: begin
                    if (!r_is_query) begin
                        r_state <= S_IDLE;
                    end else if (r_head_rd[10]) begin
                        r_q     <= r_head_rd[PIDX_W-1:0];
                        r_state <= S_PRD;
                    end else begin
                        r_state <= S_NEXT;
                    end
                end
                S_PRD: r_state <= S_PD;
                S_PD: begin
                    r_cand    <= r_pos_rd;
                    r_lnk     <= r_link_rd;
                    r_ax      <= 2'd0;
                    r_acc     <= 32'd0;
                    r_is_dist <= 1'b1;
                    r_state   <= S_AX;
                end
                S_DIST: begin
                    r_rr    <= w_rr;
                    r_state <= S_SQ;
                end
                S_SQ: begin
                    r_acc <= r_acc + w_sq;
                    if (r_ax == 2'd2) begin
                        r_state <= S_CMP;
                    end else begin
                        r_ax    <= r_ax + 2'd1;
                        r_state <= S_AX;
                    end
                end
                S_CMP: begin
                    if (w_match && (r_count == CNT_W'(MAX_NEIGHBORS))) begin
                        // one more than fits: close the request as truncated
                        if (w_out_free) begin
                            r_out_nb    <= r_pend;
                            r_out_found <= 1'b1;
                            r_out_last  <= 1'b1;
                            r_out_trunc <= 1'b1;
                            r_state     <= S_IDLE;
                        end
                    end else if (!w_match || (r_count == '0) || w_out_free) begin
                        if (w_match) begin
                            if (r_count != '0) begin
                                r_out_nb    <= r_pend;
                                r_out_found <= 1'b1;
                                r_out_last  <= 1'b0;
                                r_out_trunc <= 1'b0;
                            end
                            r_pend  <= r_q;
                            r_count <= r_count + 1'b1;
                        end
                        if (r_lnk[10]) begin
                            r_q     <= r_lnk[PIDX_W-1:0];
                            r_state <= S_PRD;
                        end else begin
                            r_state <= S_NEXT;
                        end
                    end
                end
                S_NEXT: begin
                    // x offset fastest, then y, then z
                    if (r_wx != WALK_MINUS) begin
                        r_wx    <= r_wx + 2'd1;
                        r_state <= S_CELL_A;
                    end else begin
                        r_wx <= WALK_ZERO;
                        if (r_wy != WALK_MINUS) begin
                            r_wy    <= r_wy + 2'd1;
                            r_state <= S_CELL_A;
                        end else begin
                            r_wy <= WALK_ZERO;
                            if (r_wz != WALK_MINUS) begin
                                r_wz    <= r_wz + 2'd1;
                                r_state <= S_CELL_A;
                            end else begin
                                r_state <= S_FIN;
                            end
                        end
                    end
                end
                S_FIN: begin
                    if (w_out_free) begin
                        r_out_nb    <= (r_count != '0) ? r_pend : '0;
                        r_out_found <= (r_count != '0);
                        r_out_last  <= 1'b1;
                        r_out_trunc <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_neighbor  = r_out_nb;
    assign o_found     = r_out_found;
    assign o_last      = r_out_last;
    assign o_truncated = r_out_trunc;
endmodule

FILE: rtl/clns_checker.sv
// port checker for the cell list neighbor search, bound to the top level
`timescale 1ns / 1ps
`include "cell_list_neighbor_search_macros.svh"
module clns_checker (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_in_ready,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input logic                  o_found,
    input logic                  o_last,
    input logic                  o_truncated
);
    // a result waits until it is taken
    `CLNS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid)
    // a result with nothing found is the last of its query
    `CLNS_ASSERT_IMPL(a_empty_last, i_clk, i_rst_n, o_out_valid && !o_found, o_last)
    // truncation is flagged only on a found final result
    `CLNS_ASSERT_IMPL(a_trunc_last, i_clk, i_rst_n, o_out_valid && o_truncated, o_last && o_found)
    // a request still producing results keeps the input closed
    `CLNS_ASSERT_IMPL(a_busy_mid, i_clk, i_rst_n, o_out_valid && !o_last, !o_in_ready)
endmodule

bind cell_list_neighbor_search clns_checker u_clns_checker (.*);

FILE: test/clns_result_checker.sv
// result checker of the cell list neighbor search: watches the channels and predicts results
`timescale 1ns / 1ps
module clns_result_checker (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  clns_pkg::t_kind       i_kind,
    input  clns_pkg::t_pidx       i_particle,
    input  clns_pkg::t_pos        i_pos_x,
    input  clns_pkg::t_pos        i_pos_y,
    input  clns_pkg::t_pos        i_pos_z,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  clns_pkg::t_pidx       i_neighbor,
    input  logic                  i_found,
    input  logic                  i_last,
    input  logic                  i_truncated,
    input  logic                  i_cfg_we,
    input  clns_pkg::t_cfg_idx    i_cfg_index,
    input  clns_pkg::t_cfg_data   i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_result_count,
    output int                    o_query_count
);
    import clns_pkg::*;

    typedef struct {
        t_pidx nb;
        logic  found;
        logic  last;
        logic  trunc;
    } t_hit;

    localparam int AXIS_STEP [3] = '{0, 1, -1};

    t_hit        hits_expected [$];
    logic [4:0]  cells_reg [3];
    logic [16:0] box_reg [3];
    logic [31:0] cutoff_reg;
    logic        head_ok [CELL_COUNT];
    t_pidx       head_idx [CELL_COUNT];
    logic        link_ok [MAX_PARTICLES];
    t_pidx       link_idx [MAX_PARTICLES];
    logic        on_list [MAX_PARTICLES];
    t_pos        px [MAX_PARTICLES];
    t_pos        py [MAX_PARTICLES];
    t_pos        pz [MAX_PARTICLES];

    function automatic int used_cells(logic [4:0] m);
        if (m < 5'd3) return 3;
        if (m > 5'd16) return 16;
        return int'(m);
    endfunction

    function automatic int used_box(logic [16:0] b);
        if (b == 17'd0) return 1;
        if (b > 17'd65536) return 65536;
        return int'(b);
    endfunction

    function automatic int grid_coord(t_pos p, int m, int len);
        longint c;
        c = (longint'(p) * m) / len;
        return (c > m - 1) ? m - 1 : int'(c);
    endfunction

    function automatic int wrap_coord(int i, int d, int m);
        if (d > 0) return (i + 1 >= m) ? 0 : i + 1;
        if (d < 0) return (i == 0) ? m - 1 : i - 1;
        return i;
    endfunction

    // squared periodic distance along one axis, nearest image index rounded half away from zero
    function automatic longint unsigned image_dist_sq(t_pos a, t_pos b, int len);
        longint unsigned ad, l, q, r;
        ad = (a >= b) ? longint'(a - b) : longint'(b - a);
        l  = len;
        q  = (2 * ad + l) / (2 * l);
        r  = (ad >= l * q) ? ad - l * q : l * q - ad;
        return r * r;
    endfunction

    task automatic clear_lists();
        for (int c = 0; c < CELL_COUNT; c++) begin
            head_ok[c]  = 1'b0;
            head_idx[c] = '0;
        end
        for (int p = 0; p < MAX_PARTICLES; p++) begin
            link_ok[p]  = 1'b0;
            link_idx[p] = '0;
            on_list[p]  = 1'b0;
        end
    endtask

    task automatic insert_particle(t_pidx p, t_pos x, t_pos y, t_pos z);
        int mx, my, mz, cidx;
        mx = used_cells(cells_reg[0]);
        my = used_cells(cells_reg[1]);
        mz = used_cells(cells_reg[2]);
        if (on_list[p]) return;
        px[p] = x;
        py[p] = y;
        pz[p] = z;
        cidx = grid_coord(x, mx, used_box(box_reg[0]))
             + mx * (grid_coord(y, my, used_box(box_reg[1]))
             + my * grid_coord(z, mz, used_box(box_reg[2])));
        link_ok[p]     = head_ok[cidx];
        link_idx[p]    = head_idx[cidx];
        head_ok[cidx]  = 1'b1;
        head_idx[cidx] = p;
        on_list[p]     = 1'b1;
    endtask

    task automatic predict_query(t_pidx p);
        int mx, my, mz, lx, ly, lz, ci, cj, ck, i, j, k, cidx, cnt;
        logic cut, ok;
        t_pidx q;
        longint unsigned d2;
        t_hit found_list [$];
        t_hit h;
        mx = used_cells(cells_reg[0]);
        my = used_cells(cells_reg[1]);
        mz = used_cells(cells_reg[2]);
        lx = used_box(box_reg[0]);
        ly = used_box(box_reg[1]);
        lz = used_box(box_reg[2]);
        ci = grid_coord(px[p], mx, lx);
        cj = grid_coord(py[p], my, ly);
        ck = grid_coord(pz[p], mz, lz);
        cnt = 0;
        cut = 1'b0;
        for (int n = 0; n < 27 && !cut; n++) begin
            i = wrap_coord(ci, AXIS_STEP[n % 3], mx);
            j = wrap_coord(cj, AXIS_STEP[(n / 3) % 3], my);
            k = wrap_coord(ck, AXIS_STEP[(n / 9) % 3], mz);
            cidx = i + mx * (j + my * k);
            ok = head_ok[cidx];
            q  = head_idx[cidx];
            while (ok && !cut) begin
                d2 = image_dist_sq(px[q], px[p], lx) + image_dist_sq(py[q], py[p], ly)
                   + image_dist_sq(pz[q], pz[p], lz);
                if (d2 != 0 && d2 <= longint'(cutoff_reg)) begin
                    if (cnt < MAX_NEIGHBORS) begin
                        h = '{nb: q, found: 1'b1, last: 1'b0, trunc: 1'b0};
                        found_list.push_back(h);
                        cnt++;
                    end else begin
                        cut = 1'b1;
                    end
                end
                ok = link_ok[q];
                q  = link_idx[q];
            end
        end
        if (cnt == 0) begin
            h = '{nb: '0, found: 1'b0, last: 1'b1, trunc: 1'b0};
            found_list.push_back(h);
        end else begin
            found_list[cnt-1].last  = 1'b1;
            found_list[cnt-1].trunc = cut;
        end
        foreach (found_list[n]) hits_expected.push_back(found_list[n]);
    endtask

    always @(posedge i_clk) begin
        t_hit h;
        if (!i_rst_n) begin
            cells_reg  = '{5'd4, 5'd4, 5'd4};
            box_reg    = '{17'd65536, 17'd65536, 17'd65536};
            cutoff_reg = '0;
            clear_lists();
            for (int p = 0; p < MAX_PARTICLES; p++) begin
                px[p] = '0;
                py[p] = '0;
                pz[p] = '0;
            end
            hits_expected.delete();
            o_fail_count   = 0;
            o_result_count = 0;
            o_query_count  = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                o_result_count++;
                if (hits_expected.size() == 0) begin
                    o_fail_count++;
                    $display("%t: unexpected result neighbor=%0d found=%b last=%b trunc=%b",
                             $time, i_neighbor, i_found, i_last, i_truncated);
                end else begin
                    h = hits_expected.pop_front();
                    if (i_neighbor !== h.nb || i_found !== h.found || i_last !== h.last
                        || i_truncated !== h.trunc) begin
                        o_fail_count++;
                        $display("%t: mismatch expected nb=%0d found=%b last=%b trunc=%b, %s",
                                 $time, h.nb, h.found, h.last, h.trunc, "got:");
                        $display("%t:   actual nb=%0d found=%b last=%b trunc=%b",
                                 $time, i_neighbor, i_found, i_last, i_truncated);
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_CELLS_X: cells_reg[0] = i_cfg_data[4:0];
                    CFG_CELLS_Y: cells_reg[1] = i_cfg_data[4:0];
                    CFG_CELLS_Z: cells_reg[2] = i_cfg_data[4:0];
                    CFG_BOX_X:   box_reg[0]   = i_cfg_data[16:0];
                    CFG_BOX_Y:   box_reg[1]   = i_cfg_data[16:0];
                    CFG_BOX_Z:   box_reg[2]   = i_cfg_data[16:0];
                    CFG_CUTOFF:  cutoff_reg   = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                case (i_kind)
                    KIND_CLEAR:  clear_lists();
                    KIND_INSERT: insert_particle(i_particle, i_pos_x, i_pos_y, i_pos_z);
                    KIND_QUERY: begin
                        o_query_count++;
                        predict_query(i_particle);
                    end
                    default: ;
                endcase
            end
        end
        o_pending = hits_expected.size();
    end
endmodule

FILE: test/tb_cell_list_neighbor_search.sv
// testbench top of the cell list neighbor search: stimulus, receiver stalls and verdict
`timescale 1ns / 1ps
module tb_cell_list_neighbor_search;
    import clns_pkg::*;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    t_kind     kind = KIND_CLEAR;
    t_pidx     particle = '0;
    t_pos      pos_x = '0;
    t_pos      pos_y = '0;
    t_pos      pos_z = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_pidx     neighbor;
    logic      found, last, truncated;
    logic      cfg_we = 1'b0;
    t_cfg_idx  cfg_index = CFG_CELLS_X;
    t_cfg_data cfg_data = '0;

    int fail_count, pending, result_count, query_count;
    int sent_count = 0;
    int set_count = 0;
    bit hold_rx = 1'b0;
    bit no_gaps = 1'b0;
    t_pidx placed [$];
    // particles whose position has been written at least once
    t_pidx stored [$];
    bit    stored_bit [MAX_PARTICLES];
    int box_now = 65536;
    int cells_now = 4;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    cell_list_neighbor_search dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready),
        .i_kind(kind), .i_particle(particle),
        .i_pos_x(pos_x), .i_pos_y(pos_y), .i_pos_z(pos_z),
        .o_out_valid(out_valid), .i_out_ready(out_ready),
        .o_neighbor(neighbor), .o_found(found), .o_last(last), .o_truncated(truncated),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    clns_result_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready),
        .i_kind(kind), .i_particle(particle),
        .i_pos_x(pos_x), .i_pos_y(pos_y), .i_pos_z(pos_z),
        .i_out_valid(out_valid), .i_out_ready(out_ready),
        .i_neighbor(neighbor), .i_found(found), .i_last(last), .i_truncated(truncated),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending),
        .o_result_count(result_count), .o_query_count(query_count)
    );

    // receiver: bursts of ready, short and long stalls, one long hold-off on request
    initial begin
        int r;
        forever begin
            @(posedge i_clk);
            if (hold_rx) begin
                hold_rx = 1'b0;
                out_ready <= 1'b0;
                repeat (2500) @(posedge i_clk);
            end else begin
                r = $urandom_range(0, 99);
                if (r < 55) begin
                    out_ready <= 1'b1;
                    repeat ($urandom_range(0, 40)) @(posedge i_clk);
                end else if (r < 92) begin
                    out_ready <= 1'b0;
                    repeat ($urandom_range(0, 2)) @(posedge i_clk);
                end else begin
                    out_ready <= 1'b0;
                    repeat ($urandom_range(10, 60)) @(posedge i_clk);
                end
            end
        end
    end

    initial begin
        #100_000_000;
        $display("** cell_list_neighbor_search: FAILED **");
        $finish;
    end

    task automatic send_request(t_kind k, t_pidx p, t_pos x, t_pos y, t_pos z);
        int g, r;
        r = $urandom_range(0, 99);
        g = (no_gaps || r < 50) ? 0 : (r < 90) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        if (g > 0) begin
            in_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        kind     <= k;
        particle <= p;
        pos_x    <= x;
        pos_y    <= y;
        pos_z    <= z;
        do @(posedge i_clk); while (!in_ready);
        if (k != KIND_UNUSED) sent_count++;
        if (k == KIND_CLEAR) placed.delete();
        if (k == KIND_INSERT) begin
            placed.push_back(p);
            if (!stored_bit[p]) begin
                stored_bit[p] = 1'b1;
                stored.push_back(p);
            end
        end
    endtask

    // wait until all results are in and the block has finished any silent request
    task automatic drain_block();
        if (in_valid) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        do @(posedge i_clk); while (pending != 0);
        repeat (200) @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, t_cfg_data d);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        if (idx == CFG_BOX_X) box_now = (d == 0) ? 1 : (d > 65536) ? 65536 : int'(d);
        if (idx == CFG_CELLS_X) cells_now = (d < 3) ? 3 : (d > 16) ? 16 : int'(d);
    endtask

    function automatic t_cfg_data pick_cells();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return $urandom_range(0, 2);
        if (r == 1) return $urandom_range(17, 31);
        if (r == 2) return 16;
        return $urandom_range(3, 8);
    endfunction

    function automatic t_cfg_data pick_box();
        int r;
        r = $urandom_range(0, 11);
        if (r == 0) return 0;
        if (r == 1) return 1;
        if (r == 2) return $urandom_range(65537, 131071);
        if (r < 6) return 65536;
        return $urandom_range(2, 65536);
    endfunction

    function automatic t_pos pick_pos();
        if ($urandom_range(0, 4) == 0) return t_pos'($urandom_range(0, 65535));
        return t_pos'($urandom_range(0, box_now - 1));
    endfunction

    function automatic t_pidx any_pidx();
        return t_pidx'($urandom_range(0, MAX_PARTICLES - 1));
    endfunction

    task automatic pick_config();
        longint unsigned span;
        int r;
        write_reg(CFG_CELLS_X, pick_cells());
        write_reg(CFG_CELLS_Y, pick_cells());
        write_reg(CFG_CELLS_Z, pick_cells());
        write_reg(CFG_BOX_X, pick_box());
        write_reg(CFG_BOX_Y, pick_box());
        write_reg(CFG_BOX_Z, pick_box());
        span = box_now / cells_now;
        r = $urandom_range(0, 9);
        if (r == 0) write_reg(CFG_CUTOFF, 0);
        else if (r == 1) write_reg(CFG_CUTOFF, 32'hFFFF_FFFF);
        else write_reg(CFG_CUTOFF, t_cfg_data'((span * span * $urandom_range(1, 30)) / 10));
    endtask

    initial begin
        int n_ins, n_qry;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        do @(posedge i_clk); while (!in_ready);

        // directed: unused kind, wrap-around neighbors, repeated insert, zero distance, empty grid
        write_reg(CFG_CUTOFF, 32'hFFFF_FFFF);
        send_request(KIND_UNUSED, 10'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_request(KIND_INSERT, 10'd0, 16'd0, 16'd0, 16'd0);
        send_request(KIND_INSERT, 10'd1023, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_request(KIND_INSERT, 10'd0, 16'h1234, 16'h5678, 16'h9ABC);
        send_request(KIND_INSERT, 10'd2, 16'd0, 16'd0, 16'd0);
        send_request(KIND_INSERT, 10'd3, 16'h8000, 16'h8000, 16'h8000);
        send_request(KIND_INSERT, 10'd682, 16'h5555, 16'hAAAA, 16'h4000);
        send_request(KIND_QUERY, 10'd0, 16'd0, 16'd0, 16'd0);
        send_request(KIND_QUERY, 10'd1023, 16'd0, 16'd0, 16'd0);
        send_request(KIND_QUERY, 10'd3, 16'd0, 16'd0, 16'd0);
        send_request(KIND_QUERY, 10'd2, 16'd0, 16'd0, 16'd0);
        send_request(KIND_QUERY, 10'd682, 16'd0, 16'd0, 16'd0);
        send_request(KIND_CLEAR, 10'd0, 16'd0, 16'd0, 16'd0);
        send_request(KIND_QUERY, 10'd0, 16'd0, 16'd0, 16'd0);
        send_request(KIND_INSERT, 10'd0, 16'hFFFF, 16'd0, 16'h8000);
        send_request(KIND_QUERY, 10'd0, 16'd0, 16'd0, 16'd0);
        // zero cutoff: nothing within range
        drain_block();
        write_reg(CFG_CUTOFF, 0);
        send_request(KIND_QUERY, 10'd0, 16'd0, 16'd0, 16'd0);

        // dense set past the neighbor limit, with the receiver holding off
        drain_block();
        write_reg(CFG_CELLS_X, 3);
        write_reg(CFG_CELLS_Y, 3);
        write_reg(CFG_CELLS_Z, 3);
        write_reg(CFG_CUTOFF, 32'hFFFF_FFFF);
        send_request(KIND_CLEAR, 10'd0, 16'd0, 16'd0, 16'd0);
        for (int p = 0; p < 70; p++)
            send_request(KIND_INSERT, t_pidx'(p * 13 + 100), pick_pos(), pick_pos(), pick_pos());
        hold_rx = 1'b1;
        no_gaps = 1'b1;
        for (int q = 0; q < 3; q++)
            send_request(KIND_QUERY, placed[q * 20], 16'd0, 16'd0, 16'd0);
        no_gaps = 1'b0;

        // random sets: clear, inserts, queries, with noise
        while (sent_count < 410) begin
            drain_block();
            pick_config();
            set_count++;
            no_gaps = ($urandom_range(0, 4) == 0);
            send_request(KIND_CLEAR, any_pidx(), pick_pos(), pick_pos(), pick_pos());
            n_ins = $urandom_range(4, 16);
            for (int p = 0; p < n_ins; p++) begin
                if ($urandom_range(0, 7) == 0 && placed.size() > 0)
                    send_request(KIND_INSERT, placed[$urandom_range(0, placed.size() - 1)],
                                 pick_pos(), pick_pos(), pick_pos());
                else
                    send_request(KIND_INSERT, any_pidx(),
                                 pick_pos(), pick_pos(), pick_pos());
            end
            // cell counts changed under existing lists
            if ($urandom_range(0, 5) == 0) begin
                drain_block();
                write_reg(CFG_CELLS_X, pick_cells());
                write_reg(CFG_CELLS_Z, pick_cells());
            end
            n_qry = $urandom_range(3, 8);
            for (int q = 0; q < n_qry; q++) begin
                if ($urandom_range(0, 9) == 0)
                    send_request(KIND_UNUSED, any_pidx(), pick_pos(), pick_pos(),
                                 pick_pos());
                // queries of particles that may be off the lists since the last clear
                if ($urandom_range(0, 5) == 0)
                    send_request(KIND_QUERY, stored[$urandom_range(0, stored.size() - 1)],
                                 pick_pos(), pick_pos(), pick_pos());
                else
                    send_request(KIND_QUERY, placed[$urandom_range(0, placed.size() - 1)],
                                 pick_pos(), pick_pos(), pick_pos());
            end
        end

        drain_block();
        repeat (300) @(posedge i_clk);
        $display("run covered %0d requests (%0d queries) in %0d random grid settings,",
                 sent_count, query_count, set_count);
        $display("  %0d results checked, %0d mismatches", result_count, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("** cell_list_neighbor_search: PASSED **");
        end else begin
            $display("** cell_list_neighbor_search: FAILED **");
        end
        $finish;
    end
endmodule
